### hw/rtl/ulcc_pkg.sv
package ulcc_pkg;

    // Default counter width and the fixed width of the reported fields
    localparam int COUNT_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;
    localparam int CP_BITS        = 21;

    // Line-ending bytes
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_VT = 8'h0B;
    localparam logic [7:0] BYTE_FF = 8'h0C;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // Lead byte class boundaries
    localparam logic [7:0] LEAD2_MIN   = 8'hC0;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] INVALID_MIN = 8'hF8;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // Code points that end a line
    localparam logic [CP_BITS-1:0] CP_NEL = 21'h00_0085;
    localparam logic [CP_BITS-1:0] CP_LS  = 21'h00_2028;
    localparam logic [CP_BITS-1:0] CP_PS  = 21'h00_2029;

    // Decoder state, handed between the top level and the update logic
    typedef struct packed {
        logic               cr_pending;
        logic [1:0]         bytes_left;
        logic [CP_BITS-1:0] partial_cp;
        logic               four_byte;
    } dec_state_t;

endpackage

### hw/rtl/ulcc_step.sv
module ulcc_step #(
    parameter int COUNT_BITS = ulcc_pkg::COUNT_BITS_DEF
) (
    input  logic [7:0]             data_byte,
    input  logic                   start_of_span,
    input  logic                   end_of_span,
    input  logic [COUNT_BITS-1:0]  line_cur,
    input  logic [COUNT_BITS-1:0]  col_cur,
    input  ulcc_pkg::dec_state_t   dec_cur,
    output logic [COUNT_BITS-1:0]  res_line,
    output logic [COUNT_BITS-1:0]  res_col,
    output logic                   res_start,
    output logic [COUNT_BITS-1:0]  line_next,
    output logic [COUNT_BITS-1:0]  col_next,
    output ulcc_pkg::dec_state_t   dec_next
);

    localparam int SUM_W = COUNT_BITS + 1;

    // saturating add of a small step
    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] v,
        input logic [1:0]            n
    );
        logic [SUM_W-1:0] sum;
        begin
            sum = {1'b0, v} + SUM_W'(n);
            sat_add = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
        end
    endfunction

    logic [COUNT_BITS-1:0]              line_base;
    logic [COUNT_BITS-1:0]              col_base;
    ulcc_pkg::dec_state_t               dec_base;
    logic [COUNT_BITS-1:0]              line_1;
    logic [COUNT_BITS-1:0]              col_1;
    logic [COUNT_BITS-1:0]              col_2;
    logic                               is_cont;
    logic                               truncated;
    logic [ulcc_pkg::CP_BITS-1:0]       cp_new;
    logic [1:0]                         left_m1;
    logic                               cp_breaks;

    always_comb
    begin
        line_base = start_of_span ? '0 : line_cur;
        col_base  = start_of_span ? '0 : col_cur;
        dec_base  = start_of_span ? '0 : dec_cur;

        // settle a pending CR first
        line_1 = line_base;
        col_1  = col_base;
        if (dec_base.cr_pending)
        begin
            if (!end_of_span && data_byte == ulcc_pkg::BYTE_LF)
            begin
                col_1 = sat_add(col_base, 2'd1);
            end
            else
            begin
                line_1 = sat_add(line_base, 2'd1);
                col_1  = '0;
            end
        end

        is_cont   = !end_of_span && (dec_base.bytes_left != 2'd0)
                    && (data_byte[7:6] == ulcc_pkg::CONT_TAG);
        truncated = !is_cont && (dec_base.bytes_left != 2'd0);
        col_2     = truncated ? sat_add(col_1, 2'd1) : col_1;

        res_line  = line_1;
        res_col   = col_2;
        res_start = !is_cont;

        cp_new    = {dec_base.partial_cp[ulcc_pkg::CP_BITS-7:0], data_byte[5:0]};
        left_m1   = dec_base.bytes_left - 2'd1;
        cp_breaks = (cp_new == ulcc_pkg::CP_NEL) || (cp_new == ulcc_pkg::CP_LS)
                    || (cp_new == ulcc_pkg::CP_PS);

        line_next = line_1;
        col_next  = col_2;
        dec_next  = '0;

        if (end_of_span)
        begin
            // position already settled
        end
        else if (is_cont)
        begin
            dec_next.bytes_left = left_m1;
            dec_next.partial_cp = cp_new;
            dec_next.four_byte  = dec_base.four_byte;
            if (left_m1 == 2'd0)
            begin
                dec_next = '0;
                if (cp_breaks)
                begin
                    line_next = sat_add(line_1, 2'd1);
                    col_next  = '0;
                end
                else if (dec_base.four_byte && (cp_new[ulcc_pkg::CP_BITS-1:16] != '0))
                begin
                    col_next = sat_add(col_2, 2'd2);
                end
                else
                begin
                    col_next = sat_add(col_2, 2'd1);
                end
            end
        end
        else if (data_byte == ulcc_pkg::BYTE_LF || data_byte == ulcc_pkg::BYTE_VT
                 || data_byte == ulcc_pkg::BYTE_FF)
        begin
            line_next = sat_add(line_1, 2'd1);
            col_next  = '0;
        end
        else if (data_byte == ulcc_pkg::BYTE_CR)
        begin
            dec_next.cr_pending = 1'b1;
        end
        else if (data_byte < ulcc_pkg::LEAD2_MIN || data_byte >= ulcc_pkg::INVALID_MIN)
        begin
            col_next = sat_add(col_2, 2'd1);
        end
        else if (data_byte < ulcc_pkg::LEAD3_MIN)
        begin
            dec_next.bytes_left = 2'd1;
            dec_next.partial_cp = ulcc_pkg::CP_BITS'(data_byte[4:0]);
        end
        else if (data_byte < ulcc_pkg::LEAD4_MIN)
        begin
            dec_next.bytes_left = 2'd2;
            dec_next.partial_cp = ulcc_pkg::CP_BITS'(data_byte[3:0]);
        end
        else
        begin
            dec_next.bytes_left = 2'd3;
            dec_next.partial_cp = ulcc_pkg::CP_BITS'(data_byte[2:0]);
            dec_next.four_byte  = 1'b1;
        end
    end

endmodule

### hw/rtl/utf8_line_column_counter_top.sv
// UTF-8 line/column tracker.
// Input stream (s_*): one word per source byte. s_tdata[7:0] is the byte,
// s_tuser set clears line, column and decoder state before the byte,
// s_tlast marks an end word that carries no byte and reports the position
// after the last byte. Output stream (m_*): one word per input word.
// m_tdata[31:0] is the zero-based line, m_tdata[63:32] the zero-based
// column in UTF-16 units (both saturating), m_tuser is set when the byte
// begins a code point (always set on end words).
// LF, VT, FF, U+0085, U+2028, U+2029 end a line; CR ends a line unless LF
// follows. Code points needing a surrogate pair count two columns.
// An accepted word is registered in the input register, then processed and
// loaded into the output register, which drives m_tvalid.
// Throughput: one word per cycle while m_tready stays high, set by the
// combinational counter update between the input and output registers.
// Reset clears all counters and decoder state and empties both stages.
// When the receiver stalls the output word holds; the input register still
// takes one more word, then s_tready drops until the output drains.
module utf8_line_column_counter_top #(
    parameter int COUNT_BITS = ulcc_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // start_of_span
    input  logic        s_tlast,   // end_of_span
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] line, [63:32] column
    output logic        m_tuser    // at_code_point_start
);

    localparam int OB = ulcc_pkg::OUT_BITS;

    // input stage
    logic                  in_valid_reg;
    logic [7:0]            in_data_reg;
    logic                  in_start_reg;
    logic                  in_end_reg;

    // tracker state
    logic [COUNT_BITS-1:0] line_reg;
    logic [COUNT_BITS-1:0] col_reg;
    ulcc_pkg::dec_state_t  dec_reg;

    // output stage
    logic                  out_valid_reg;
    logic [OB-1:0]         out_line_reg;
    logic [OB-1:0]         out_col_reg;
    logic                  out_start_reg;

    logic                  out_ready;
    logic                  advance;
    logic                  in_accept;

    logic [COUNT_BITS-1:0] res_line;
    logic [COUNT_BITS-1:0] res_col;
    logic                  res_start;
    logic [COUNT_BITS-1:0] line_next;
    logic [COUNT_BITS-1:0] col_next;
    ulcc_pkg::dec_state_t  dec_next;
    logic [OB-1:0]         line_clamped;
    logic [OB-1:0]         col_clamped;

    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    ulcc_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .data_byte     (in_data_reg),
        .start_of_span (in_start_reg),
        .end_of_span   (in_end_reg),
        .line_cur      (line_reg),
        .col_cur       (col_reg),
        .dec_cur       (dec_reg),
        .res_line      (res_line),
        .res_col       (res_col),
        .res_start     (res_start),
        .line_next     (line_next),
        .col_next      (col_next),
        .dec_next      (dec_next)
    );

    // report width is fixed; wider counters clamp
    if (COUNT_BITS > OB)
    begin : g_clamp
        assign line_clamped = (res_line[COUNT_BITS-1:OB] != '0) ? {OB{1'b1}} : res_line[OB-1:0];
        assign col_clamped  = (res_col[COUNT_BITS-1:OB] != '0) ? {OB{1'b1}} : res_col[OB-1:0];
    end
    else
    begin : g_extend
        assign line_clamped = OB'(res_line);
        assign col_clamped  = OB'(res_col);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
            col_reg       <= '0;
            dec_reg       <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                line_reg      <= line_next;
                col_reg       <= col_next;
                dec_reg       <= dec_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_end_reg   <= s_tlast;
        end
        if (advance)
        begin
            out_line_reg  <= line_clamped;
            out_col_reg   <= col_clamped;
            out_start_reg <= res_start;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg, out_line_reg};
    assign m_tuser  = out_start_reg;

    // a pending CR never coexists with an open multi-byte sequence
    a_cr_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        dec_reg.cr_pending |-> (dec_reg.bytes_left == 2'd0))
        else $error("CR pending while a sequence is open");

    // idle decoder holds no leftover code point bits
    a_seq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_reg.bytes_left == 2'd0) |-> (dec_reg.partial_cp == '0 && !dec_reg.four_byte))
        else $error("stale sequence state with no bytes left");

    // start and end together report the origin
    a_start_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_start_reg && in_end_reg) |=> (m_tdata == '0 && m_tuser))
        else $error("start+end word did not report zero");

    // end words always mark a code point start
    a_end_start: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_end_reg) |=> m_tuser)
        else $error("end word reported inside a code point");

endmodule

### verif/tb.sv
// Line/column tracker bench: a short directed table (line endings, CR
// resolution, multi-byte code points, stray and truncated bytes, span
// start/end), then a long run of mostly well-formed UTF-8 text with noise.
// Every accepted output word is checked against an in-bench predictor or a hand-written result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1325;  // random text after the directed table
    localparam int TAIL_WORDS   = 150;   // last words sent with no idling
    localparam int HOLD_AFTER   = 300;   // results seen before the long output stall
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_MAX   = 10;

    // one input word
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } text_word_t;

    // one output word as the predictor sees it
    typedef struct packed {
        logic [ulcc_pkg::OUT_BITS-1:0] line;
        logic [ulcc_pkg::OUT_BITS-1:0] column;
        logic                          cp_start;
    } position_t;

    // directed row: word, flag for a hand-written result, that result
    typedef struct packed {
        text_word_t word;
        logic       typed;
        position_t  want;
    } directed_row_t;

    localparam position_t NO_POS = '0;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tuser;    // start_of_span
    logic        s_tlast;    // end_of_span
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // [31:0] line, [63:32] column
    logic        m_tuser;    // at_code_point_start

    utf8_line_column_counter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of counters and decoder state
    // ------------------------------------------------------------------
    logic [ulcc_pkg::OUT_BITS-1:0] line_now;
    logic [ulcc_pkg::OUT_BITS-1:0] col_now;
    ulcc_pkg::dec_state_t          decoder;

    position_t   expected_words[$];
    text_word_t  text_q[$];
    int          mismatches   = 0;
    int          results_seen = 0;
    bit          quiet_tail   = 1'b0;
    bit          next_start   = 1'b0;

    // saturating add
    function automatic logic [ulcc_pkg::OUT_BITS-1:0] bump(
        input logic [ulcc_pkg::OUT_BITS-1:0] v,
        input int unsigned                   n
    );
        if (v > {ulcc_pkg::OUT_BITS{1'b1}} - ulcc_pkg::OUT_BITS'(n))
            return {ulcc_pkg::OUT_BITS{1'b1}};
        return v + ulcc_pkg::OUT_BITS'(n);
    endfunction

    function automatic void break_line();
        line_now = bump(line_now, 1);
        col_now  = '0;
    endfunction

    function automatic void drop_sequence();
        decoder.bytes_left = '0;
        decoder.partial_cp = '0;
        decoder.four_byte  = 1'b0;
    endfunction

    // sequence cut short: worth one column
    function automatic void close_truncated();
        if (decoder.bytes_left != 0)
        begin
            col_now = bump(col_now, 1);
            drop_sequence();
        end
    endfunction

    function automatic void close_code_point();
        logic [ulcc_pkg::CP_BITS-1:0] cp;
        cp = decoder.partial_cp;
        if (cp == ulcc_pkg::CP_NEL || cp == ulcc_pkg::CP_LS || cp == ulcc_pkg::CP_PS)
            break_line();
        else if (decoder.four_byte && cp >= 21'h01_0000)
            col_now = bump(col_now, 2);  // surrogate pair
        else
            col_now = bump(col_now, 1);
        drop_sequence();
    endfunction

    // Position reported for one word, then the state update it causes.
    function automatic position_t advance_position(input text_word_t w);
        position_t pos;
        logic [7:0] b;
        b = w.data;

        if (w.start)
        begin
            line_now = '0;
            col_now  = '0;
            decoder  = '0;
        end

        // a held CR is settled by whatever comes next
        if (decoder.cr_pending)
        begin
            decoder.cr_pending = 1'b0;
            if (!w.last && b == ulcc_pkg::BYTE_LF)
                col_now = bump(col_now, 1);
            else
                break_line();
        end

        if (w.last)
        begin
            close_truncated();
            pos = '{line: line_now, column: col_now, cp_start: 1'b1};
            return pos;
        end

        if (decoder.bytes_left != 0 && b[7:6] == ulcc_pkg::CONT_TAG)
        begin
            pos = '{line: line_now, column: col_now, cp_start: 1'b0};
            decoder.partial_cp = {decoder.partial_cp[ulcc_pkg::CP_BITS-7:0], b[5:0]};
            decoder.bytes_left = decoder.bytes_left - 2'd1;
            if (decoder.bytes_left == 0)
                close_code_point();
            return pos;
        end

        close_truncated();
        pos = '{line: line_now, column: col_now, cp_start: 1'b1};

        if (b == ulcc_pkg::BYTE_LF || b == ulcc_pkg::BYTE_VT || b == ulcc_pkg::BYTE_FF)
            break_line();
        else if (b == ulcc_pkg::BYTE_CR)
            decoder.cr_pending = 1'b1;
        else if (b < ulcc_pkg::LEAD2_MIN || b >= ulcc_pkg::INVALID_MIN)
            col_now = bump(col_now, 1);  // ASCII, stray continuation, invalid
        else if (b < ulcc_pkg::LEAD3_MIN)
        begin
            decoder.bytes_left = 2'd1;
            decoder.partial_cp = ulcc_pkg::CP_BITS'(b[4:0]);
        end
        else if (b < ulcc_pkg::LEAD4_MIN)
        begin
            decoder.bytes_left = 2'd2;
            decoder.partial_cp = ulcc_pkg::CP_BITS'(b[3:0]);
        end
        else
        begin
            decoder.bytes_left = 2'd3;
            decoder.partial_cp = ulcc_pkg::CP_BITS'(b[2:0]);
            decoder.four_byte  = 1'b1;
        end
        return pos;
    endfunction

    // ------------------------------------------------------------------
    // Random text building
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        text_q.push_back('{data: b, start: next_start, last: 1'b0});
        next_start = 1'b0;
    endtask

    // encode cp in n bytes (overlong if n is larger than needed), emit the
    // first keep of them
    task automatic put_cp(input int unsigned cp, input int n, input int keep);
        logic [7:0] seq [4];
        case (n)
            2:       seq[0] = 8'hC0 | 8'((cp >> 6) & 32'h1F);
            3:       seq[0] = 8'hE0 | 8'((cp >> 12) & 32'h0F);
            default: seq[0] = 8'hF0 | 8'((cp >> 18) & 32'h07);
        endcase
        for (int k = 1; k < n; k++)
            seq[k] = 8'h80 | 8'((cp >> (6 * (n - 1 - k))) & 32'h3F);
        for (int k = 0; k < keep; k++)
            put_byte(seq[k]);
    endtask

    // ------------------------------------------------------------------
    // Sender: drive at the falling edge, accept at the rising edge
    // ------------------------------------------------------------------
    task automatic send_word(input text_word_t w, input logic typed, input position_t want);
        position_t pred;
        // random gap before this word
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w.data;
        s_tuser  <= w.start;
        s_tlast  <= w.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = advance_position(w);
        expected_words.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Directed table. Hand-written results only where obvious.
    directed_row_t directed_rows [26];

    initial
    begin
        directed_rows = '{
            {8'h41, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0, 1'b1},  // start of span, 'A'
            {8'h0A, 1'b0, 1'b0, 1'b1, 32'd0, 32'd1, 1'b1},  // LF
            {8'h0B, 1'b0, 1'b0, 1'b0, NO_POS},              // VT
            {8'h0C, 1'b0, 1'b0, 1'b0, NO_POS},              // FF
            {8'h0D, 1'b0, 1'b0, 1'b0, NO_POS},              // CR ...
            {8'h0A, 1'b0, 1'b0, 1'b0, NO_POS},              // ... LF: CR is a column
            {8'h0D, 1'b0, 1'b0, 1'b0, NO_POS},              // CR ...
            {8'h00, 1'b0, 1'b0, 1'b0, NO_POS},              // ... non-LF: CR ends line
            {8'hC2, 1'b0, 1'b0, 1'b0, NO_POS},              // U+0085 next line
            {8'h85, 1'b0, 1'b0, 1'b0, NO_POS},
            {8'hE2, 1'b0, 1'b0, 1'b0, NO_POS},              // U+2029 paragraph sep
            {8'h80, 1'b0, 1'b0, 1'b0, NO_POS},
            {8'hA9, 1'b0, 1'b0, 1'b0, NO_POS},
            {8'hF0, 1'b0, 1'b0, 1'b0, NO_POS},              // U+1F600: two columns
            {8'h9F, 1'b0, 1'b0, 1'b0, NO_POS},
            {8'h98, 1'b0, 1'b0, 1'b0, NO_POS},
            {8'h80, 1'b0, 1'b0, 1'b0, NO_POS},
            {8'h80, 1'b0, 1'b0, 1'b0, NO_POS},              // stray continuation
            {8'hFF, 1'b0, 1'b0, 1'b0, NO_POS},              // invalid byte
            {8'hF7, 1'b0, 1'b0, 1'b0, NO_POS},              // oversized lead ...
            {8'h41, 1'b0, 1'b0, 1'b0, NO_POS},              // ... cut short by ASCII
            {8'h0D, 1'b0, 1'b0, 1'b0, NO_POS},              // CR settled by end word
            {8'hA5, 1'b0, 1'b1, 1'b0, NO_POS},
            {8'h5A, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0, 1'b1},  // start and end together
            {8'hC1, 1'b0, 1'b0, 1'b0, NO_POS},              // overlong lead ...
            {8'h00, 1'b0, 1'b1, 1'b0, NO_POS}               // ... cut short by end word
        };
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        int          n;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        line_now = '0;
        col_now  = '0;
        decoder  = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Random text: mostly well-formed tokens, some noise.
        while (text_q.size() < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 49) == 0)
                next_start = 1'b1;
            if (pick < 35)
                put_byte(8'($urandom_range(8'h20, 8'h7E)));
            else if (pick < 45)
            begin
                case ($urandom_range(0, 4))
                    0: put_byte(ulcc_pkg::BYTE_LF);
                    1: put_byte(ulcc_pkg::BYTE_VT);
                    2: put_byte(ulcc_pkg::BYTE_FF);
                    3: put_byte(ulcc_pkg::BYTE_CR);
                    default:
                    begin
                        put_byte(ulcc_pkg::BYTE_CR);
                        put_byte(ulcc_pkg::BYTE_LF);
                    end
                endcase
            end
            else if (pick < 55)
                put_cp(($urandom_range(0, 3) == 0) ? 32'h85 : $urandom_range(32'h80, 32'h7FF),
                       2, 2);
            else if (pick < 65)
            begin
                case ($urandom_range(0, 5))
                    0:       put_cp(32'h2028, 3, 3);
                    1:       put_cp(32'h2029, 3, 3);
                    default: put_cp($urandom_range(32'h800, 32'hFFFF), 3, 3);
                endcase
            end
            else if (pick < 75)
                put_cp($urandom_range(32'h1_0000, 32'h10_FFFF), 4, 4);
            else if (pick < 80)
            begin
                // end of span; its data byte is ignored
                text_q.push_back('{data: 8'($urandom),
                                   start: next_start | ($urandom_range(0, 5) == 0),
                                   last: 1'b1});
                next_start = 1'b0;
            end
            else if (pick < 87)
            begin
                // truncated sequence
                n = $urandom_range(2, 4);
                put_cp($urandom_range(32'h80, 32'h10_FFFF), n, $urandom_range(1, n - 1));
            end
            else if (pick < 92)
            begin
                // overlong and oversized forms
                case ($urandom_range(0, 3))
                    0: put_cp(32'h85, 3, 3);
                    1: put_cp($urandom_range(0, 32'hFFFF), 4, 4);
                    2: put_cp($urandom_range(0, 32'h7F), 2, 2);
                    default: put_cp($urandom_range(32'h11_0000, 32'h1F_FFFF), 4, 4);
                endcase
            end
            else if (pick < 96)
                put_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                     : 8'($urandom_range(8'hF8, 8'hFF)));
            else
            begin
                // anything at all
                text_q.push_back('{data: 8'($urandom), start: 1'($urandom), last: 1'($urandom)});
                next_start = 1'b0;
            end
        end

        foreach (text_q[i])
        begin
            if (i >= text_q.size() - TAIL_WORDS)
                quiet_tail = 1'b1;
            send_word(text_q[i], 1'b0, NO_POS);
        end
        s_tvalid <= 1'b0;

        // drain; the watchdog covers a hang here
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off to fill the block
    // ------------------------------------------------------------------
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 11) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output check
    // ------------------------------------------------------------------
    position_t got_word;
    position_t want_word;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got_word = '{line: m_tdata[31:0], column: m_tdata[63:32], cp_start: m_tuser};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] unexpected word: line %0d col %0d start %0b",
                             $realtime, got_word.line, got_word.column, got_word.cp_start);
            end
            else
            begin
                want_word = expected_words.pop_front();
                if (got_word.line !== want_word.line || got_word.column !== want_word.column ||
                    got_word.cp_start !== want_word.cp_start)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"[%0t] word %0d: exp line %0d col %0d start %0b, ",
                                  "got line %0d col %0d start %0b"},
                                 $realtime, results_seen - 1, want_word.line, want_word.column,
                                 want_word.cp_start, got_word.line, got_word.column,
                                 got_word.cp_start);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule

### filelist.f
hw/rtl/ulcc_pkg.sv
hw/rtl/ulcc_step.sv
hw/rtl/utf8_line_column_counter_top.sv
verif/tb.sv
